// File: design/peu_pkg.sv
// Shared types, constants and tables for the particle emitter update block.
package peu_pkg;

  localparam int unsigned PARTICLES_DEF        = 64;
  localparam int unsigned FRAMES_PER_COLOR_DEF = 30;
  localparam int unsigned COLOR_BANDS          = 12;
  localparam logic [14:0] GRAVITY_Q12          = 15'd28127;
  localparam logic [6:0]  BUDGET_MAX           = 7'd127;
  localparam logic [23:0] ELAPSED_MAX          = 24'hFFFFFF;

  localparam logic [1:0] REG_EMITTER_X = 2'd0;
  localparam logic [1:0] REG_EMITTER_Y = 2'd1;
  localparam logic [1:0] REG_EMITTER_Z = 2'd2;
  localparam logic [1:0] REG_RUNNING   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_SQRT,
    ST_DIV_X,
    ST_DIV_Y,
    ST_DIV_Z,
    ST_MUL_A,
    ST_MUL_B,
    ST_SUM,
    ST_DONE
  } peu_state_t;

  typedef struct packed {
    logic load;
    logic mem_read;
    logic sqrt_start;
    logic sqrt_step;
    logic div_start;
    logic [1:0] div_axis;
    logic div_step;
    logic mul_a;
    logic mul_b;
    logic sum;
    logic finish;
  } peu_cmd_t;

  typedef struct packed {
    logic slot_ok;
    logic spawn;
    logic zero_dir;
    logic sqrt_done;
    logic div_done;
  } peu_status_t;

  function automatic logic [23:0] band_color(input logic [3:0] band);
    case (band)
      4'd0:    band_color = {8'd254, 8'd247, 8'd237};
      4'd1:    band_color = {8'd251, 8'd238, 8'd219};
      4'd2:    band_color = {8'd255, 8'd236, 8'd178};
      4'd3:    band_color = {8'd249, 8'd226, 8'd146};
      4'd4:    band_color = {8'd249, 8'd206, 8'd104};
      4'd5:    band_color = {8'd239, 8'd137, 8'd65};
      4'd6:    band_color = {8'd231, 8'd95, 8'd46};
      4'd7:    band_color = {8'd229, 8'd71, 8'd36};
      4'd8:    band_color = {8'd202, 8'd56, 8'd33};
      4'd9:    band_color = {8'd157, 8'd32, 8'd28};
      4'd10:   band_color = {8'd98, 8'd20, 8'd18};
      4'd11:   band_color = {8'd66, 8'd18, 8'd16};
      default: band_color = 24'd0;
    endcase
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [49:0] v);
    if (v > 50'sd8388607) sat24 = 24'sh7FFFFF;
    else if (v < -50'sd8388608) sat24 = 24'sh800000;
    else sat24 = v[23:0];
  endfunction

endpackage

// File: design/particle_emitter_update.sv
// Top level of the particle emitter update block: registers, controller and datapath.
// A request for a live or empty slot shows its result with done high after the read, the
// products and the sum; a spawn with a nonzero direction adds a square root and three
// divisions, done on the shared root and divider.
// Only one request at a time; busy stays high through the result cycle, so a new request
// is taken only once the last one is through.
// Reset clears the registers and all active flags and sets the spawn budget to one.
module particle_emitter_update #(
  parameter int unsigned PARTICLES        = peu_pkg::PARTICLES_DEF,
  parameter int unsigned FRAMES_PER_COLOR = peu_pkg::FRAMES_PER_COLOR_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               start,
  output logic               busy,
  input  logic [5:0]         slot,
  input  logic               frame_start,
  input  logic [15:0]        time_step,
  input  logic signed [13:0] rand_x,
  input  logic [13:0]        rand_y,
  input  logic signed [13:0] rand_z,
  input  logic [3:0]         rand_speed,
  output logic               done,
  output logic [5:0]         out_slot,
  output logic               alive,
  output logic signed [23:0] pos_x,
  output logic signed [23:0] pos_y,
  output logic signed [23:0] pos_z,
  output logic [7:0]         color_r,
  output logic [7:0]         color_g,
  output logic [7:0]         color_b,
  output logic               was_drawn
);
  import peu_pkg::*;

  // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
  logic signed [23:0] emitter_x, emitter_y, emitter_z;
  logic running;

  always_ff @(posedge clk) begin
    if (rst) begin
      emitter_x <= '0;
      emitter_y <= '0;
      emitter_z <= '0;
      running   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EMITTER_X: emitter_x <= cfg_data;
        REG_EMITTER_Y: emitter_y <= cfg_data;
        REG_EMITTER_Z: emitter_z <= cfg_data;
        REG_RUNNING:   running   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  peu_cmd_t    cmd;
  peu_status_t status;

  // The controller sequences read, optional spawn math, products and write-back.
  peu_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .running (running),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  // The datapath holds the slot stores, spawn budget and all arithmetic.
  peu_dp #(
    .PARTICLES        (PARTICLES),
    .FRAMES_PER_COLOR (FRAMES_PER_COLOR)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .emitter_x   (emitter_x),
    .emitter_y   (emitter_y),
    .emitter_z   (emitter_z),
    .slot        (slot),
    .frame_start (frame_start),
    .time_step   (time_step),
    .rand_x      (rand_x),
    .rand_y      (rand_y),
    .rand_z      (rand_z),
    .rand_speed  (rand_speed),
    .done        (done),
    .out_slot    (out_slot),
    .alive       (alive),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .color_r     (color_r),
    .color_g     (color_g),
    .color_b     (color_b),
    .was_drawn   (was_drawn)
  );
endmodule

// File: design/peu_ctrl.sv
// Controller state machine for the particle emitter update block.
module peu_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 running,
  input  peu_pkg::peu_status_t status,
  output peu_pkg::peu_cmd_t    cmd,
  output logic                 busy
);
  import peu_pkg::*;

  peu_state_t state, state_next;
  logic [1:0] axis, axis_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      axis  <= 2'd0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

  always_comb begin
    state_next = state;
    axis_next  = axis;
    case (state)
      ST_IDLE: if (start && running) state_next = ST_READ;
      ST_READ: begin
        if (!status.slot_ok) state_next = ST_IDLE;
        else if (status.spawn && !status.zero_dir) state_next = ST_SQRT;
        else state_next = ST_MUL_A;
      end
      ST_SQRT: if (status.sqrt_done) begin
        state_next = ST_DIV_X;
        axis_next  = 2'd0;
      end
      ST_DIV_X: if (status.div_done) begin
        if (axis == 2'd2) state_next = ST_MUL_A;
        axis_next = axis + 2'd1;
      end
      ST_MUL_A: state_next = ST_MUL_B;
      ST_MUL_B: state_next = ST_SUM;
      ST_SUM:   state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.div_axis = axis;
    case (state)
      ST_IDLE: cmd.load = start && running;
      ST_READ: begin
        cmd.mem_read   = 1'b1;
        cmd.sqrt_start = status.slot_ok && status.spawn && !status.zero_dir;
      end
      ST_SQRT: begin
        cmd.sqrt_step = !status.sqrt_done;
        cmd.div_start = status.sqrt_done;
        cmd.div_axis  = 2'd0;
      end
      ST_DIV_X: begin
        cmd.div_step  = !status.div_done;
        cmd.div_start = status.div_done && axis != 2'd2;
        cmd.div_axis  = status.div_done ? axis + 2'd1 : axis;
      end
      ST_MUL_A: cmd.mul_a  = 1'b1;
      ST_MUL_B: cmd.mul_b  = 1'b1;
      ST_SUM:   cmd.sum    = 1'b1;
      ST_DONE:  cmd.finish = 1'b1;
      default: ;
    endcase
  end

  assign busy = state != ST_IDLE;
endmodule

// File: design/peu_dp.sv
// Datapath of the particle emitter update block: slot stores, root, divider, products.
module peu_dp #(
  parameter int unsigned PARTICLES        = peu_pkg::PARTICLES_DEF,
  parameter int unsigned FRAMES_PER_COLOR = peu_pkg::FRAMES_PER_COLOR_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  peu_pkg::peu_cmd_t    cmd,
  output peu_pkg::peu_status_t status,
  input  logic signed [23:0]   emitter_x,
  input  logic signed [23:0]   emitter_y,
  input  logic signed [23:0]   emitter_z,
  input  logic [5:0]           slot,
  input  logic                 frame_start,
  input  logic [15:0]          time_step,
  input  logic signed [13:0]   rand_x,
  input  logic [13:0]          rand_y,
  input  logic signed [13:0]   rand_z,
  input  logic [3:0]           rand_speed,
  output logic                 done,
  output logic [5:0]           out_slot,
  output logic                 alive,
  output logic signed [23:0]   pos_x,
  output logic signed [23:0]   pos_y,
  output logic signed [23:0]   pos_z,
  output logic [7:0]           color_r,
  output logic [7:0]           color_g,
  output logic [7:0]           color_b,
  output logic                 was_drawn
);
  import peu_pkg::*;

  localparam int unsigned IDX_W  = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
  localparam int unsigned MAX_BAND_AGE = COLOR_BANDS * FRAMES_PER_COLOR;
  localparam int unsigned AGE_W  = $clog2(MAX_BAND_AGE + 1);

  // One wide word per slot: vel x/y/z, orig x/y/z, elapsed, age.
  localparam int unsigned ROW_W = 7 * 24 + AGE_W;
  logic [ROW_W-1:0] mem [PARTICLES];
  logic [PARTICLES-1:0] active_flag;
  logic [6:0] spawn_budget;

  logic [5:0] slot_q;
  logic [15:0] step_q;
  logic signed [13:0] rx_q, rz_q;
  logic [13:0] ry_q;
  logic [3:0] speed_q;
  logic signed [23:0] ex_q, ey_q, ez_q;
  logic [ROW_W-1:0] row_q;
  logic [IDX_W-1:0] idx;
  logic slot_ok, act_cur, spawn_q;

  assign idx     = IDX_W'(slot_q);
  assign slot_ok = {26'd0, slot_q} < 32'(PARTICLES);
  assign act_cur = active_flag[idx];

  // Load of the request at accept; read of the slot row.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      slot_q  <= slot;
      step_q  <= time_step;
      rx_q    <= rand_x;
      ry_q    <= rand_y;
      rz_q    <= rand_z;
      speed_q <= rand_speed;
      ex_q    <= emitter_x;
      ey_q    <= emitter_y;
      ez_q    <= emitter_z;
    end
    row_q <= mem[idx];
  end

  logic signed [27:0] sx2, sz2;
  logic [27:0] sy2;
  logic [29:0] sq_sum;
  assign sx2    = rx_q * rx_q;
  assign sy2    = ry_q * ry_q;
  assign sz2    = rz_q * rz_q;
  assign sq_sum = {2'b0, sx2} + {2'b0, sy2} + {2'b0, sz2};

  assign status.slot_ok  = slot_ok;
  assign status.spawn    = !act_cur && spawn_budget != 7'd0;
  assign status.zero_dir = sq_sum == 30'd0;

  // Bit-serial integer square root of sq_sum * 65536 (46 bits, 23 steps).
  logic [45:0] sq_n, sq_r, sq_bit;
  logic [45:0] sq_trial;
  assign sq_trial = sq_r + sq_bit;
  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      sq_n   <= {sq_sum, 16'd0};
      sq_r   <= '0;
      sq_bit <= 46'd1 << 44;
    end else if (cmd.sqrt_step) begin
      if (sq_n >= sq_trial) begin
        sq_n <= sq_n - sq_trial;
        sq_r <= (sq_r >> 1) + sq_bit;
      end else begin
        sq_r <= sq_r >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end
  assign status.sqrt_done = sq_bit == 46'd0;

  // Restoring divider: (|r|*speed*2^20 + L/2) / L, one quotient bit per cycle.
  logic [23:0] len;
  assign len = sq_r[23:0];
  logic [13:0] mag_sel;
  logic neg_sel;
  always_comb begin
    case (cmd.div_axis)
      2'd0:    begin mag_sel = rx_q[13] ? 14'(-rx_q) : rx_q; neg_sel = rx_q[13]; end
      2'd1:    begin mag_sel = ry_q; neg_sel = 1'b0; end
      default: begin mag_sel = rz_q[13] ? 14'(-rz_q) : rz_q; neg_sel = rz_q[13]; end
    endcase
  end

  logic [38:0] dv_num;
  logic [38:0] dv_q;
  logic [24:0] dv_rem;
  logic [5:0]  dv_cnt;
  logic [1:0]  dv_axis;
  logic        dv_neg;
  logic [24:0] dv_sh;
  assign dv_sh = {dv_rem[23:0], dv_num[38]};
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dv_num  <= {1'b0, 18'(mag_sel) * 18'(speed_q), 20'd0} + 39'(len >> 1);
      dv_rem  <= '0;
      dv_cnt  <= 6'd39;
      dv_axis <= cmd.div_axis;
      dv_neg  <= neg_sel;
    end else if (cmd.div_step) begin
      dv_num <= {dv_num[37:0], 1'b0};
      if (dv_sh >= {1'b0, len}) begin
        dv_rem <= dv_sh - {1'b0, len};
        dv_q   <= {dv_q[37:0], 1'b1};
      end else begin
        dv_rem <= dv_sh;
        dv_q   <= {dv_q[37:0], 1'b0};
      end
      dv_cnt <= dv_cnt - 6'd1;
    end
  end
  assign status.div_done = dv_cnt == 6'd0;

  // Marks the one cycle in which a freshly finished quotient is on dv_q.
  logic dv_last;
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_last <= 1'b0;
    end else begin
      dv_last <= cmd.div_step && dv_cnt == 6'd1;
    end
  end

  // New velocity of a spawning slot, written as each quotient finishes.
  logic signed [23:0] nvx, nvy, nvz;
  logic signed [49:0] dv_sig;
  assign dv_sig = dv_neg ? -$signed({11'd0, dv_q}) : $signed({11'd0, dv_q});
  always_ff @(posedge clk) begin
    if (cmd.mem_read) begin
      spawn_q <= status.spawn;
      nvx <= '0;
      nvy <= '0;
      nvz <= '0;
    end else if (dv_last && spawn_q) begin
      case (dv_axis)
        2'd0:    nvx <= sat24(dv_sig);
        2'd1:    nvy <= sat24(dv_sig);
        default: nvz <= sat24(dv_sig);
      endcase
    end
  end

  // Effective slot state: fresh values after a spawn.
  logic signed [23:0] vx, vy, vz, ox, oy, oz;
  logic [23:0] el;
  logic [AGE_W-1:0] ag;
  always_comb begin
    if (spawn_q) begin
      vx = nvx; vy = nvy; vz = nvz;
      ox = ex_q; oy = ey_q; oz = ez_q;
      el = '0; ag = '0;
    end else begin
      {vx, vy, vz, ox, oy, oz, el, ag} = row_q;
    end
  end

  // Products, stage A: velocity times time and time squared.
  logic signed [41:0] px_p, py_p, pz_p;
  logic [47:0] t2;
  always_ff @(posedge clk) begin
    if (cmd.mul_a) begin
      px_p <= vx * $signed({1'b0, el[16:0]}) + ((vx * $signed({1'b0, el[23:17]})) <<< 17);
      py_p <= vy * $signed({1'b0, el[16:0]}) + ((vy * $signed({1'b0, el[23:17]})) <<< 17);
      pz_p <= vz * $signed({1'b0, el[16:0]}) + ((vz * $signed({1'b0, el[23:17]})) <<< 17);
      t2   <= el * el;
    end
  end

  function automatic logic signed [49:0] rnd16(input logic signed [49:0] p);
    logic [49:0] m;
    m = p[49] ? 50'(-p) : 50'(p);
    m = (m + 50'd32768) >> 16;
    rnd16 = p[49] ? -$signed(m) : $signed(m);
  endfunction

  // Stage B: gravity term and rounding of the velocity products.
  logic signed [49:0] gx, gy, gz, grav;
  logic [32:0] tsq;
  logic [47:0] gprod;
  assign tsq   = 33'((t2 + 48'd32768) >> 16);
  assign gprod = 48'(tsq) * 48'(GRAVITY_Q12);
  always_ff @(posedge clk) begin
    if (cmd.mul_b) begin
      gx   <= rnd16(50'(px_p));
      gy   <= rnd16(50'(py_p));
      gz   <= rnd16(50'(pz_p));
      grav <= rnd16($signed({2'b0, gprod}));
    end
  end

  // Final sums, despawn checks and store write.
  logic signed [23:0] fx, fy, fz;
  logic [3:0] band;
  logic past_last;
  logic [24:0] ne;
  assign fx = sat24(gx + 50'(ox));
  assign fy = sat24(gy - grav + 50'(oy));
  assign fz = sat24(gz + 50'(oz));
  assign past_last = 32'(ag) >= 32'(MAX_BAND_AGE);
  assign ne = {1'b0, el} + {9'd0, step_q};

  // The age band is found by comparing the age against each band boundary.
  always_comb begin
    band = 4'd0;
    for (int unsigned k = 1; k < COLOR_BANDS; k++) begin
      if (32'(ag) >= k * FRAMES_PER_COLOR) band = 4'(k);
    end
  end

  logic live;
  assign live = act_cur || spawn_q;

  always_ff @(posedge clk) begin
    if (cmd.sum && live) begin
      mem[idx] <= {vx, vy, vz, ox, oy, oz,
                   past_last ? el : (ne[24] ? ELAPSED_MAX : ne[23:0]),
                   past_last ? ag : ag + AGE_W'(1)};
    end
  end

  logic kill;
  assign kill = live && (past_last || fy < 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_flag  <= '0;
      spawn_budget <= 7'd1;
    end else if (cmd.load && frame_start) begin
      spawn_budget <= 7'd1;
    end else if (cmd.sum) begin
      if (kill) begin
        active_flag[idx] <= 1'b0;
        if (spawn_q) begin
          // spawn consumed one and despawn refunds one
        end else if (spawn_budget != BUDGET_MAX) begin
          spawn_budget <= spawn_budget + 7'd1;
        end
      end else if (spawn_q) begin
        active_flag[idx] <= 1'b1;
        spawn_budget     <= spawn_budget - 7'd1;
      end
    end
  end

  logic [23:0] col;
  assign col = band_color(band);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.sum;
    end
    if (cmd.sum) begin
      out_slot  <= slot_q;
      alive     <= live && !kill;
      was_drawn <= live;
      pos_x     <= live ? fx : '0;
      pos_y     <= live ? fy : '0;
      pos_z     <= live ? fz : '0;
      {color_r, color_g, color_b} <= (live && !past_last) ? col : 24'd0;
    end
  end
endmodule

// File: design/peu_checker.sv
// Port-level checks for the particle emitter update block and their binding.
module peu_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic       alive,
  input logic       was_drawn,
  input logic [7:0] color_r,
  input logic [7:0] color_g,
  input logic [7:0] color_b
);
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe lasted more than one cycle");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without a request in work");
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    (busy && !$past(busy)) |-> $past(start)) else $error("busy without a request");
  a_alive_drawn: assert property (@(posedge clk) disable iff (rst)
    (done && alive) |-> was_drawn) else $error("alive slot not drawn");
  a_color_drawn: assert property (@(posedge clk) disable iff (rst)
    (done && !was_drawn) |-> (color_r == 8'd0 && color_g == 8'd0 && color_b == 8'd0))
    else $error("color on an undrawn slot");
endmodule

bind particle_emitter_update peu_checker u_peu_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .alive(alive),
  .was_drawn(was_drawn), .color_r(color_r), .color_g(color_g), .color_b(color_b)
);
